### rtl/core/gps_pkg.sv
package gps_pkg;

  localparam int SIZE_W      = 7;
  localparam int SIZE_MAX    = 2**SIZE_W - 1;
  localparam int OP_W        = 2;
  localparam int COORD_W     = 6;
  localparam int DIGIT_W     = 4;
  localparam int REG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [OP_W-1:0] OP_GRID    = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_ROWS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_COLS = 2'd3;

  localparam logic [SIZE_W-1:0] RST_GRID_ROWS    = 7'd64;
  localparam logic [SIZE_W-1:0] RST_GRID_COLS    = 7'd64;
  localparam logic [SIZE_W-1:0] RST_PATTERN_ROWS = 7'd1;
  localparam logic [SIZE_W-1:0] RST_PATTERN_COLS = 7'd1;

endpackage

### rtl/core/grid_pattern_search.sv
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       opcode, cell_row, cell_col, digit
// m_*       out        m_tvalid / m_tready       found
// cfg_*     in         cfg_we (no wait)          cfg_index, cfg_data
//
// Cell loads are accepted back to back.
// A search alternates a read state and a compare state for each cell compare; each
// compare reads one cell from each store, and each store has a single read port.
// Reset clears control state and sets the sizes to their reset values; the cell stores keep their contents.
// A finished result waits in the output register; loads go on meanwhile, and a
// search holds its end until the output register is free.
module grid_pattern_search import gps_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [IN_TDATA_W-1:0]      s_tdata,   // opcode[1:0], cell_row[7:2], cell_col[13:8], digit[17:14]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_TDATA_W-1:0]     m_tdata,   // found[0]
  input  logic                       cfg_we,
  input  logic [REG_IDX_W-1:0]       cfg_index,
  input  logic [SIZE_W-1:0]          cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW1   = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] ROW_TOP =
    (MAX_ROWS > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COL_TOP =
    (MAX_COLS > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(MAX_COLS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] top);
    return (v > top) ? top : v;
  endfunction

  logic [1:0]         state;
  logic [SIZE_W-1:0]  grid_rows, grid_cols, pattern_rows, pattern_cols;
  logic [SIZE_W-1:0]  gr, gc, pr, pc;
  logic [SIZE_W-1:0]  r0, c0, r, c;
  logic               found_res;
  logic               m_found;

  logic [OP_W-1:0]    opcode;
  logic [COORD_W-1:0] cell_row, cell_col;
  logic [DIGIT_W-1:0] digit;

  logic               accept, start, in_range;
  logic               g_we, p_we;
  logic [AW-1:0]      waddr, g_raddr, p_raddr;
  logic [SIZE_W-1:0]  g_row, g_col;
  logic [DIGIT_W-1:0] g_rdata, p_rdata;
  logic [SIZE_W-1:0]  cgr, cgc, cpr, cpc;
  logic               size_bad;
  logic               hit, more_c, more_r, more_c0, more_r0;

  assign opcode   = s_tdata[1:0];
  assign cell_row = s_tdata[7:2];
  assign cell_col = s_tdata[13:8];
  assign digit    = s_tdata[17:14];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign start    = accept && (opcode == OP_SEARCH);

  assign in_range = (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);
  assign g_we     = accept && (opcode == OP_GRID) && in_range;
  assign p_we     = accept && (opcode == OP_PATTERN) && in_range;
  assign waddr    = AW'(int'(cell_row) * MAX_COLS + int'(cell_col));

  assign g_row    = r0 + r;
  assign g_col    = c0 + c;
  assign g_raddr  = AW'(int'(g_row) * MAX_COLS + int'(g_col));
  assign p_raddr  = AW'(int'(r) * MAX_COLS + int'(c));

  gps_ram #(.WIDTH(DIGIT_W), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (waddr),
    .wdata (digit),
    .re    (state == ST_READ),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  gps_ram #(.WIDTH(DIGIT_W), .DEPTH(DEPTH)) u_pattern (
    .clk   (clk),
    .we    (p_we),
    .waddr (waddr),
    .wdata (digit),
    .re    (state == ST_READ),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign cgr = clamp_size(grid_rows, ROW_TOP);
  assign cgc = clamp_size(grid_cols, COL_TOP);
  assign cpr = clamp_size(pattern_rows, ROW_TOP);
  assign cpc = clamp_size(pattern_cols, COL_TOP);
  assign size_bad = (cgr == '0) || (cgc == '0) || (cpr == '0) || (cpc == '0) ||
                    (cpr > cgr) || (cpc > cgc);

  assign hit     = (g_rdata == p_rdata);
  assign more_c  = (SW1'(c) + SW1'(1)) < SW1'(pc);
  assign more_r  = (SW1'(r) + SW1'(1)) < SW1'(pr);
  assign more_c0 = (SW1'(c0) + SW1'(pc)) < SW1'(gc);
  assign more_r0 = (SW1'(r0) + SW1'(pr)) < SW1'(gr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      grid_rows    <= RST_GRID_ROWS;
      grid_cols    <= RST_GRID_COLS;
      pattern_rows <= RST_PATTERN_ROWS;
      pattern_cols <= RST_PATTERN_COLS;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_ROWS:    grid_rows    <= cfg_data;
          REG_GRID_COLS:    grid_cols    <= cfg_data;
          REG_PATTERN_ROWS: pattern_rows <= cfg_data;
          REG_PATTERN_COLS: pattern_cols <= cfg_data;
          default: ;
        endcase
      end
      if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= size_bad ? ST_FIN : ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (hit && !more_c && !more_r) begin
            state <= ST_FIN;
          end else if (!hit && !more_c0 && !more_r0) begin
            state <= ST_FIN;
          end else begin
            state <= ST_READ;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gr        <= cgr;
      gc        <= cgc;
      pr        <= cpr;
      pc        <= cpc;
      r0        <= '0;
      c0        <= '0;
      r         <= '0;
      c         <= '0;
      found_res <= 1'b0;
    end
    if (state == ST_CMP) begin
      if (hit) begin
        if (more_c) begin
          c <= c + SIZE_W'(1);
        end else if (more_r) begin
          c <= '0;
          r <= r + SIZE_W'(1);
        end else begin
          found_res <= 1'b1;
        end
      end else begin
        r <= '0;
        c <= '0;
        if (more_c0) begin
          c0 <= c0 + SIZE_W'(1);
        end else if (more_r0) begin
          c0 <= '0;
          r0 <= r0 + SIZE_W'(1);
        end
      end
    end
    if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
      m_found <= found_res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, m_found};

endmodule

### rtl/core/gps_ram.sv
module gps_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/gps_checker.sv
module gps_checker import gps_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[1:0] == OP_SEARCH) |=> !s_tready)
    else $error("input taken while a search runs");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[1:0] != OP_SEARCH) |=> s_tready)
    else $error("cell load stalled the input");

  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a search");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind grid_pattern_search gps_checker u_gps_checker (.*);
